// ===== hdl/rope_pkg.sv =====
// Package for the rotary position embedding block: widths, register indexes,
// CORDIC constants and the pipeline payload types. No dependencies.
`default_nettype none
package rope_pkg;
  localparam int MaxPairs    = 128;
  localparam int PairW       = 7;
  localparam int MaxWidth    = 4096;
  localparam int IdxW        = 12;
  localparam int CordicSteps = 24;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 32;
  localparam int CordW       = 34;

  localparam logic [CfgIdxW-1:0] RegHeadSize    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWidth    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInterleaved = 2'd2;

  localparam logic kind_rotate = 1'b0;
  localparam logic kind_load   = 1'b1;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CordW-1:0] OneQ30     = 34'sd1073741824;

  typedef struct packed {
    logic [15:0] position;
    logic [11:0] head_offset;
    logic [6:0]  pair_index;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        is_key;
    logic [31:0] frequency_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] first_result;
    logic [31:0] second_result;
    logic [11:0] first_index;
    logic [11:0] second_index;
    logic        rotated;
  } out_item_t;

  // Payload that rides alongside the CORDIC pipe.
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic [11:0]        first_index;
    logic [11:0]        second_index;
    logic               rotated;
    logic [1:0]         quadrant;
  } side_t;

  function automatic logic signed [CordW-1:0] atan_turns(input int i);
    logic signed [CordW-1:0] t;
    unique case (i)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
      24: t = 34'sd41;        25: t = 34'sd20;        26: t = 34'sd10;
      27: t = 34'sd5;         28: t = 34'sd3;         29: t = 34'sd1;
      30: t = 34'sd1;         default: t = 34'sd0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/rope_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on rope_pkg.
`default_nettype none
interface rope_in_if;
  logic valid;
  logic ready;
  logic kind;
  rope_pkg::in_item_t data;
  modport source (output valid, kind, data, input ready);
  modport sink (input valid, kind, data, output ready);
endinterface

interface rope_out_if;
  logic valid;
  logic ready;
  rope_pkg::out_item_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface rope_cfg_if;
  logic valid;
  logic ready;
  logic [rope_pkg::CfgIdxW-1:0] index;
  logic [rope_pkg::CfgDataW-1:0] value;
  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface
`default_nettype wire

// ===== hdl/rope_cordic.sv =====
// CORDIC pipeline: one register stage per rotation step, stalled by a global enable.
// Depends on rope_pkg.
`default_nettype none
module rope_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [29:0]          angle,
  input  wire rope_pkg::side_t      in_side,
  output logic                      out_valid,
  output logic signed [33:0]        cos_q30,
  output logic signed [33:0]        sin_q30,
  output rope_pkg::side_t           out_side
);
  import rope_pkg::*;

  logic                    valid [1:CordicSteps];
  logic signed [CordW-1:0] xs    [1:CordicSteps];
  logic signed [CordW-1:0] ys    [1:CordicSteps];
  logic signed [CordW-1:0] zs    [1:CordicSteps];
  side_t                   sides [1:CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic                    v_i;
    logic signed [CordW-1:0] x_i, y_i, z_i;
    side_t                   s_i;
    if (i == 0) begin : g_first
      assign v_i = in_valid;
      assign x_i = CordicGain;
      assign y_i = '0;
      assign z_i = CordW'({2'b00, angle});
      assign s_i = in_side;
    end else begin : g_next
      assign v_i = valid[i];
      assign x_i = xs[i];
      assign y_i = ys[i];
      assign z_i = zs[i];
      assign s_i = sides[i];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sides[i+1] <= s_i;
        if (!z_i[CordW-1]) begin
          xs[i+1] <= x_i - (y_i >>> i);
          ys[i+1] <= y_i + (x_i >>> i);
          zs[i+1] <= z_i - atan_turns(i);
        end else begin
          xs[i+1] <= x_i + (y_i >>> i);
          ys[i+1] <= y_i - (x_i >>> i);
          zs[i+1] <= z_i + atan_turns(i);
        end
      end
    end
  end

  assign out_valid = valid[CordicSteps];
  assign cos_q30   = xs[CordicSteps];
  assign sin_q30   = ys[CordicSteps];
  assign out_side  = sides[CordicSteps];
endmodule
`default_nettype wire

// ===== hdl/rope_rotate.sv =====
// Rotation back end: clamp and quadrant fold, four products, round and saturate.
// Depends on rope_pkg.
`default_nettype none
module rope_rotate (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic signed [33:0] cx,
  input  wire logic signed [33:0] cy,
  input  wire rope_pkg::side_t  in_side,
  output logic                  out_valid,
  output rope_pkg::out_item_t   out_item
);
  import rope_pkg::*;

  logic signed [CordW-1:0] xc, yc, c_n, s_n;
  logic signed [CordW-1:0] c_r, s_r;
  side_t sd_a, sd_b, sd_c;
  logic v_a, v_b, v_c;
  logic signed [65:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [67:0] acc0, acc1;

  function automatic logic signed [CordW-1:0] clampq(input logic signed [CordW-1:0] v);
    if (v > OneQ30) return OneQ30;
    if (v < -OneQ30) return -OneQ30;
    return v;
  endfunction

  function automatic logic [31:0] scale_sat(input logic signed [67:0] a);
    logic signed [67:0] r;
    r = (a + 68'sd536870912) >>> 30;
    if (r > 68'sd2147483647) return 32'h7FFFFFFF;
    if (r < -68'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  always_comb begin
    xc = clampq(cx);
    yc = clampq(cy);
    unique case (in_side.quadrant)
      2'd0: begin c_n = xc;  s_n = yc;  end
      2'd1: begin c_n = -yc; s_n = xc;  end
      2'd2: begin c_n = -xc; s_n = -yc; end
      default: begin c_n = yc; s_n = -xc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0; v_b <= 1'b0; v_c <= 1'b0;
    end else if (en) begin
      v_a <= in_valid; v_b <= v_a; v_c <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r  <= c_n;
      s_r  <= s_n;
      sd_a <= in_side;
      p_xc <= 66'($signed(sd_a.x0)) * 66'(c_r);
      p_ys <= 66'($signed(sd_a.x1)) * 66'(s_r);
      p_xs <= 66'($signed(sd_a.x0)) * 66'(s_r);
      p_yc <= 66'($signed(sd_a.x1)) * 66'(c_r);
      sd_b <= sd_a;
      acc0 <= 68'(p_xc) - 68'(p_ys);
      acc1 <= 68'(p_xs) + 68'(p_yc);
      sd_c <= sd_b;
    end
  end

  always_comb begin
    out_valid              = v_c;
    out_item.first_index   = sd_c.first_index;
    out_item.second_index  = sd_c.second_index;
    out_item.rotated       = sd_c.rotated;
    if (sd_c.rotated) begin
      out_item.first_result  = scale_sat(acc0);
      out_item.second_result = scale_sat(acc1);
    end else begin
      out_item.first_result  = sd_c.x0;
      out_item.second_result = sd_c.x1;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rotary_position_embedding.sv =====
// Rotary position embedding top level: config registers, frequency table, phase
// multiply, CORDIC pipe, rotation back end and output register. Uses rope_pkg.
// One item per cycle is accepted unless the output stalls.
// The whole pipe advances together and holds when the output register is full and stalled.
// Load items write the table and give no result. Reset clears valid bits and
// registers (head length 128, key_width 4096, interleaved 0); the table is not cleared.
`default_nettype none
module rotary_position_embedding (
  input wire logic clk,
  input wire logic rst,
  rope_in_if.sink   in_ch,
  rope_cfg_if.sink  cfg,
  rope_out_if.source out_ch
);
  import rope_pkg::*;

  logic [8:0]  head_len;
  logic [12:0] key_width;
  logic        interleaved;
  logic [31:0] freq_mem [MaxPairs];

  logic en;
  logic in_acc;

  // stage 1: table read
  logic        v1;
  logic [31:0] f1;
  in_item_t    d1;
  // stage 2: phase product
  logic        v2;
  logic [31:0] ph2;
  side_t       sd2;
  logic [11:0] o0, o1;
  logic [7:0]  half;

  logic        cv;
  logic signed [33:0] cx, cy;
  side_t       cs;
  logic        rv;
  out_item_t   ritem;
  logic        ov;
  out_item_t   oitem;

  assign en          = !ov || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready   = 1'b1;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_len <= 9'd128; key_width <= 13'd4096; interleaved <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegHeadSize:    head_len    <= cfg.value[8:0];
        RegKeyWidth:    key_width   <= cfg.value[12:0];
        RegInterleaved: interleaved <= cfg.value[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.kind == kind_load) begin
      freq_mem[in_ch.data.pair_index] <= in_ch.data.frequency_word;
    end
    if (en) begin
      f1 <= freq_mem[in_ch.data.pair_index];
      d1 <= in_ch.data;
    end
  end

  always_comb begin
    half = head_len[8:1];
    if (interleaved) begin
      o0 = 12'({d1.pair_index, 1'b0}) + d1.head_offset;
      o1 = 12'({d1.pair_index, 1'b1}) + d1.head_offset;
    end else begin
      o0 = d1.head_offset + 12'(d1.pair_index);
      o1 = d1.head_offset + 12'(d1.pair_index) + 12'(half);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_acc && in_ch.kind == kind_rotate;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph2              <= 32'(d1.position * f1);
      sd2.x0           <= d1.first_value;
      sd2.x1           <= d1.second_value;
      sd2.first_index  <= o0;
      sd2.second_index <= o1;
      sd2.rotated      <= !(d1.is_key && 13'(d1.head_offset) >= key_width);
      sd2.quadrant     <= 2'b00;
    end
  end

  side_t sd2q;
  always_comb begin
    sd2q = sd2;
    sd2q.quadrant = ph2[31:30];
  end

  rope_cordic u_cordic (
    .clk, .rst, .en, .in_valid(v2), .angle(ph2[29:0]), .in_side(sd2q),
    .out_valid(cv), .cos_q30(cx), .sin_q30(cy), .out_side(cs)
  );

  rope_rotate u_rotate (
    .clk, .rst, .en, .in_valid(cv), .cx, .cy, .in_side(cs),
    .out_valid(rv), .out_item(ritem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= rv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) oitem <= ritem;
  end

  assign out_ch.valid = ov;
  assign out_ch.data  = oitem;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_load_none: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.kind == kind_load |=> !v1)
    else $error("load item entered pipe");
endmodule
`default_nettype wire

// ===== dv/tb_rotary_position_embedding.sv =====
// Self-checking testbench for rotary_position_embedding: directed table, then
// randomized phases over the three registers, all results checked in order.
// Depends on rope_pkg and the channel interfaces in rope_if.sv.
module tb_rotary_position_embedding;
  import rope_pkg::*;

  typedef struct {
    logic      kind;
    in_item_t  d;
    bit        typed;
    out_item_t e;
  } stim_row_t;

  localparam longint AtanTurns [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838, 5340245,
    2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic clk;
  logic rst;
  rope_in_if  in_ch();
  rope_cfg_if cfg();
  rope_out_if out_ch();

  rotary_position_embedding dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
  );

  logic [31:0] freq_table [MaxPairs];
  bit          loaded [MaxPairs];
  logic [8:0]  head_len_reg;
  logic [12:0] key_width_reg;
  logic        interleaved_reg;
  out_item_t   pending_rotations [$];
  stim_row_t   directed_rows [$];
  int          errors;
  bit          no_gaps;
  bit          pressure_req;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] scale_sat(longint acc);
    longint r;
    r = (acc + (64'sd1 <<< 29)) >>> 30;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    return r[31:0];
  endfunction

  function automatic out_item_t rotate_pair(in_item_t d);
    out_item_t o;
    longint x, y, z, dx, dy, c, s, a0, a1;
    logic [31:0] ph;
    logic [11:0] off0, off1;
    if (interleaved_reg) begin
      off0 = {d.pair_index, 1'b0};
      off1 = {d.pair_index, 1'b1};
    end else begin
      off0 = d.pair_index;
      off1 = d.pair_index + head_len_reg[8:1];
    end
    o.first_index = d.head_offset + off0;
    o.second_index = d.head_offset + off1;
    if (d.is_key && {1'b0, d.head_offset} >= key_width_reg) begin
      o.first_result = d.first_value;
      o.second_result = d.second_value;
      o.rotated = 1'b0;
      return o;
    end
    ph = d.position * freq_table[d.pair_index];
    z = ph[29:0];
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurns[i];
      end else begin
        x += dx; y -= dy; z += AtanTurns[i];
      end
    end
    if (x > 1073741824) x = 1073741824;
    if (x < -1073741824) x = -1073741824;
    if (y > 1073741824) y = 1073741824;
    if (y < -1073741824) y = -1073741824;
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    a0 = longint'($signed(d.first_value));
    a1 = longint'($signed(d.second_value));
    o.first_result = scale_sat(a0 * c - a1 * s);
    o.second_result = scale_sat(a0 * s + a1 * c);
    o.rotated = 1'b1;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    out_item_t got, want;
    forever begin
      @(negedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = out_ch.data;
        if (pending_rotations.size() == 0) begin
          report_mismatch("unexpected result", got.first_result, 32'h0);
        end else begin
          want = pending_rotations.pop_front();
          if (got.first_result !== want.first_result)
            report_mismatch("first_result", got.first_result, want.first_result);
          if (got.second_result !== want.second_result)
            report_mismatch("second_result", got.second_result, want.second_result);
          if (got.first_index !== want.first_index)
            report_mismatch("first_index", got.first_index, want.first_index);
          if (got.second_index !== want.second_index)
            report_mismatch("second_index", got.second_index, want.second_index);
          if (got.rotated !== want.rotated)
            report_mismatch("rotated", got.rotated, want.rotated);
        end
      end
    end
  end

  initial begin
    int r;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        pressure_req = 0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (no_gaps) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) stall_left = $urandom_range(10, 60);
        out_ch.ready <= (r >= 30);
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    bit acc;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.value <= val;
    forever begin
      @(negedge clk);
      acc = cfg.ready;
      @(posedge clk);
      if (acc) break;
    end
    cfg.valid <= 1'b0;
    case (idx)
      RegHeadSize: head_len_reg = val[8:0];
      RegKeyWidth: key_width_reg = val[12:0];
      RegInterleaved: interleaved_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic send_item(logic kind, in_item_t d, bit typed, out_item_t e);
    bit acc;
    int r, gap;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.data <= d;
    forever begin
      @(negedge clk);
      acc = in_ch.ready;
      @(posedge clk);
      if (acc) break;
    end
    if (kind == kind_load) begin
      freq_table[d.pair_index] = d.frequency_word;
      loaded[d.pair_index] = 1;
    end else begin
      pending_rotations.push_back(typed ? e : rotate_pair(d));
    end
    r = $urandom_range(0, 99);
    gap = no_gaps ? 0 : (r < 55 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(logic kind, logic [15:0] pos, logic [11:0] ofs, logic [6:0] pair,
                         logic [31:0] v0, logic [31:0] v1, logic key, logic [31:0] fw);
    stim_row_t row;
    row.kind = kind;
    row.d = '{pos, ofs, pair, v0, v1, key, fw};
    row.typed = 0;
    row.e = '0;
    directed_rows.push_back(row);
  endtask

  initial begin
    in_item_t d;
    out_item_t none;
    int hs [6] = '{2, 256, 7, 0, 511, 128};
    int kw [6] = '{0, 8191, 2048, 4095, 1, 4096};
    int il [6] = '{1, 0, 1, 0, 1, 0};
    errors = 0;
    no_gaps = 0;
    pressure_req = 0;
    none = '0;
    foreach (loaded[i]) loaded[i] = 0;
    head_len_reg = 9'd128;
    key_width_reg = 13'd4096;
    interleaved_reg = 1'b0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.kind <= kind_rotate;
    in_ch.data <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= RegHeadSize;
    cfg.value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(RegKeyWidth, 32'd2048);

    add_row(kind_load, 0, 0, 0, 0, 0, 0, 32'h20000000);
    add_row(kind_load, 0, 0, 1, 0, 0, 0, 32'h00000000);
    add_row(kind_load, 16'hFFFF, 12'hFFF, 127, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'hFFFFFFFF);
    add_row(kind_load, 0, 0, 2, 0, 0, 0, 32'h40000000);
    add_row(kind_rotate, 1, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0);
    add_row(kind_rotate, 1, 0, 0, 32'h80000000, 32'h80000000, 0, 0);
    add_row(kind_rotate, 1, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0);
    add_row(kind_rotate, 16'hFFFF, 12'h010, 1, 32'h00010000, 32'hFFFF0000, 0, 0);
    add_row(kind_rotate, 0, 0, 1, 0, 0, 0, 0);
    add_row(kind_rotate, 16'hFFFF, 12'hFFF, 127, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    add_row(kind_rotate, 3, 12'h7FF, 2, 32'h00010000, 32'h00020000, 1, 0);
    add_row(kind_rotate, 2, 12'h100, 2, 32'h80000000, 32'h00000001, 0, 0);
    add_row(kind_rotate, 16'h8000, 12'h7FF, 127, 32'h12345678, 32'h9ABCDEF0, 1, 0);
    add_row(kind_rotate, 16'h1234, 12'h900, 3, 32'h12345678, 32'h80000000, 1, 0);
    directed_rows[$].typed = 1;
    directed_rows[$].e = '{32'h12345678, 32'h80000000, 12'h903, 12'h943, 1'b0};
    add_row(kind_rotate, 0, 12'hFFF, 5, 32'h7FFFFFFF, 32'h00000000, 1, 0);
    directed_rows[$].typed = 1;
    directed_rows[$].e = '{32'h7FFFFFFF, 32'h00000000, 12'h004, 12'h044, 1'b0};
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].d, directed_rows[i].typed,
                directed_rows[i].e);
    in_ch.valid <= 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(RegHeadSize, hs[p]);
      write_reg(RegKeyWidth, kw[p]);
      write_reg(RegInterleaved, il[p]);
      no_gaps = (p == 3);
      if (p == 1) pressure_req = 1;
      for (int n = 0; n < 200; n++) begin
        d.position = $urandom;
        d.head_offset = $urandom;
        d.pair_index = $urandom;
        d.first_value = pick_value();
        d.second_value = pick_value();
        d.is_key = $urandom;
        d.frequency_word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom;
        if ($urandom_range(0, 99) < 15 || !loaded[d.pair_index])
          send_item(kind_load, d, 0, none);
        else
          send_item(kind_rotate, d, 0, none);
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
